>>> rtl/core/dcd_pkg.sv
// Package for the double clap detector.
// It holds the transaction structs, the configuration struct, the register index, mode
// and sequencer enums and the fixed-point constants. It depends on nothing.
`default_nettype none
package dcd_pkg;

	localparam int LVL_W = 26;
	localparam int THR_W = 30;

	typedef struct packed {
		logic [9:0]  sample;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic        double_clap;
		logic        waiting_second;
		logic [31:0] first_clap_time;
	} result_t;

	typedef struct packed {
		logic [9:0]  lockout_ms;
		logic [11:0] gap_min_ms;
		logic [11:0] fast_gap_min_ms;
		logic [15:0] gap_max_ms;
		logic [15:0] listen_timeout_ms;
		logic [11:0] cooldown_ms;
		logic [7:0]  quiet_rearm_ms;
		logic        fast_enable;
	} cfg_t;

	typedef struct packed {
		logic    res_valid;
		result_t res;
	} back_out_t;

	typedef enum logic [2:0] {
		REG_LOCKOUT      = 3'd0,
		REG_GAP_MIN      = 3'd1,
		REG_FAST_GAP_MIN = 3'd2,
		REG_GAP_MAX      = 3'd3,
		REG_TIMEOUT      = 3'd4,
		REG_COOLDOWN     = 3'd5,
		REG_QUIET_REARM  = 3'd6,
		REG_FAST_ENABLE  = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_SECOND  = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WR,
		ST_SCAN,
		ST_THR,
		ST_REL_DEV,
		ST_REL_SW,
		ST_L_BASE,
		ST_L_DEV,
		ST_L_SW,
		ST_DEC
	} seq_t;

	localparam logic [THR_W-1:0] Q_18 = THR_W'(18 * 65536);
	localparam logic [THR_W-1:0] Q_24 = THR_W'(24 * 65536);
	localparam logic [THR_W-1:0] Q_14 = THR_W'(14 * 65536);
	localparam logic [THR_W-1:0] Q_16 = THR_W'(16 * 65536);
	localparam logic [THR_W-1:0] Q_10 = THR_W'(10 * 65536);
	localparam logic [THR_W-1:0] Q_6  = THR_W'(6 * 65536);
	localparam logic [THR_W-1:0] Q_4  = THR_W'(4 * 65536);
	localparam logic [THR_W-1:0] Q_22 = THR_W'(22 * 65536);
	localparam logic [THR_W-1:0] Q_26 = THR_W'(26 * 65536);
	localparam logic [LVL_W-1:0] SW_MIN  = LVL_W'(2 * 65536);
	localparam logic [LVL_W-1:0] SW_MAX  = LVL_W'(80 * 65536);
	localparam logic [LVL_W-1:0] DEV_MIN = LVL_W'(39322);
	localparam logic [LVL_W-1:0] DEVF_RST = LVL_W'(65536);
	localparam logic [LVL_W-1:0] SWF_RST  = LVL_W'(6 * 65536);
	localparam logic [16:0] K_RELEASE = 17'd43254;
	localparam logic [16:0] K_BASE    = 17'd393;
	localparam logic [16:0] K_FLOOR   = 17'd983;
	localparam logic [31:0] LEARN_HOLDOFF = 32'd250;

endpackage
`default_nettype wire

>>> rtl/core/dcd_front.sv
// Front of the double clap detector: a two-entry queue of sample transactions.
// Depends on dcd_pkg.
`default_nettype none
module dcd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  dcd_pkg::item_t     item,
	output logic               full,
	input  wire logic          take,
	output logic               avail,
	output dcd_pkg::item_t     head
);
	dcd_pkg::item_t ent_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           do_push, do_take;

	assign full    = (cnt_q == 2'd2);
	assign avail   = (cnt_q != 2'd0);
	assign head    = ent_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_take = take && avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_take) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_take};
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/dcd_back.sv
// Back of the double clap detector: ring window, window scan, thresholds,
// floor learning on one shared multiplier, and the clap state machine.
// Depends on dcd_pkg.
`default_nettype none
module dcd_back #(
	parameter int WINDOW_SAMPLES = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  dcd_pkg::cfg_t        cfg,
	input  wire logic            avail,
	input  dcd_pkg::item_t       head,
	input  wire logic            out_busy,
	output logic                 take,
	output dcd_pkg::back_out_t   bo
);
	localparam int AW = $clog2(WINDOW_SAMPLES);
	localparam int FW = $clog2(WINDOW_SAMPLES + 1);
	localparam int LW = dcd_pkg::LVL_W;
	localparam int TW = dcd_pkg::THR_W;

	dcd_pkg::seq_t  st_q, st_d;
	dcd_pkg::mode_t mode_q;
	dcd_pkg::item_t cur_q;

	logic [9:0]    mem [WINDOW_SAMPLES];
	logic [AW-1:0] head_q;
	logic [FW-1:0] fill_q, idx_q;
	logic          rd_vld_s1;
	logic [9:0]    rd_data_s1;
	logic [9:0]    wmin_q, wmax_q;

	logic [LW-1:0] base_q, devf_q, swf_q, dev_q, p2p_q;
	logic [TW-1:0] fdev_q, fsw_q, sdev_q, ssw_q, rel_dev_q;
	logic          quiet_q, learn_q;
	logic signed [47:0] prod_q;
	logic [31:0]   lastc_q, stamp_q, qsince_q, toggle_q;
	logic          qv_q;

	logic signed [30:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [47:0] rnd_full;
	logic signed [33:0] rnd;
	logic [LW-1:0] raw_q16;
	logic          quiet_now;
	logic [30:0]   devf9;
	logic [TW-1:0] fdev_c, fsw_c, sdev_c, ssw_c;
	logic [LW-1:0] new_base, new_devf, new_swf;

	// decision outputs
	dcd_pkg::mode_t nx_mode;
	logic [31:0] nx_lastc, nx_stamp, nx_qsince, nx_toggle;
	logic        nx_qv, dclap;
	logic        locked, first_cand, second_cand, fast;
	logic [31:0] dt;

	function automatic logic [LW-1:0] clamp_lvl(input logic signed [33:0] x);
		logic [LW-1:0] r;
		if (x < 0) r = '0;
		else if (x > 34'sd67108863) r = '1;
		else r = x[LW-1:0];
		return r;
	endfunction

	assign raw_q16 = {cur_q.sample, 16'd0};
	assign take    = (st_q == dcd_pkg::ST_IDLE) && avail && !out_busy;

	// ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (st_q == dcd_pkg::ST_WR) begin
			mem[head_q] <= cur_q.sample;
		end
		rd_data_s1 <= mem[idx_q[AW-1:0]];
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			dcd_pkg::ST_REL_DEV: begin
				mul_a = signed'({1'b0, sdev_q});
				mul_b = signed'(dcd_pkg::K_RELEASE);
			end
			dcd_pkg::ST_REL_SW: begin
				mul_a = signed'({1'b0, ssw_q});
				mul_b = signed'(dcd_pkg::K_RELEASE);
			end
			dcd_pkg::ST_L_BASE: begin
				mul_a = signed'(31'(raw_q16)) - signed'(31'(base_q));
				mul_b = signed'(dcd_pkg::K_BASE);
			end
			dcd_pkg::ST_L_DEV: begin
				mul_a = signed'(31'(dev_q)) - signed'(31'(devf_q));
				mul_b = signed'(dcd_pkg::K_FLOOR);
			end
			dcd_pkg::ST_L_SW: begin
				mul_a = signed'(31'(p2p_q)) - signed'(31'(swf_q));
				mul_b = signed'(dcd_pkg::K_FLOOR);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// divide by 65536, nearest, ties up
	assign rnd_full  = (prod_q + 48'sd32768) >>> 16;
	assign rnd       = rnd_full[33:0];
	assign quiet_now = ({4'd0, dev_q} <= rel_dev_q) && ({4'd0, p2p_q} <= rnd[TW-1:0]);

	// thresholds from the floors
	always_comb begin
		devf9  = 31'(devf_q) * 31'd9 + 31'd1;
		fdev_c = TW'(devf_q) * TW'(6) + dcd_pkg::Q_6;
		if (fdev_c < dcd_pkg::Q_18) fdev_c = dcd_pkg::Q_18;
		sdev_c = devf9[TW:1] + dcd_pkg::Q_6;
		if (sdev_c < dcd_pkg::Q_14) sdev_c = dcd_pkg::Q_14;
		fsw_c = TW'(swf_q) * TW'(4) + dcd_pkg::Q_4;
		if (fsw_c < dcd_pkg::Q_24) fsw_c = dcd_pkg::Q_24;
		ssw_c = TW'(swf_q) * TW'(3) + dcd_pkg::Q_4;
		if (ssw_c < dcd_pkg::Q_16) ssw_c = dcd_pkg::Q_16;
	end

	// learning updates
	always_comb begin
		new_base = clamp_lvl(signed'(34'(base_q)) + rnd);
		new_devf = clamp_lvl(signed'(34'(devf_q)) + rnd);
		if (new_devf < dcd_pkg::DEV_MIN) new_devf = dcd_pkg::DEV_MIN;
		new_swf = clamp_lvl(signed'(34'(swf_q)) + rnd);
		if (new_swf < dcd_pkg::SW_MIN) new_swf = dcd_pkg::SW_MIN;
		if (new_swf > dcd_pkg::SW_MAX) new_swf = dcd_pkg::SW_MAX;
	end

	// clap decision
	always_comb begin
		nx_mode   = mode_q;
		nx_lastc  = lastc_q;
		nx_stamp  = stamp_q;
		nx_qsince = qsince_q;
		nx_toggle = toggle_q;
		nx_qv     = qv_q;
		dclap     = 1'b0;
		dt        = cur_q.now_ms - stamp_q;
		locked    = (cur_q.now_ms - lastc_q) < {22'd0, cfg.lockout_ms};
		first_cand = !locked && (({4'd0, dev_q} >= fdev_q) ||
			(({4'd0, p2p_q} >= fsw_q) && ({4'd0, dev_q} >= dcd_pkg::Q_10)));
		second_cand = !locked && (({4'd0, dev_q} >= sdev_q) ||
			(({4'd0, p2p_q} >= ssw_q) && ({4'd0, dev_q} >= dcd_pkg::Q_6)));
		fast = cfg.fast_enable && !locked && (dt >= {20'd0, cfg.fast_gap_min_ms}) &&
			(dt <= {16'd0, cfg.gap_max_ms}) &&
			({4'd0, dev_q} >= sdev_q) && ({4'd0, dev_q} >= dcd_pkg::Q_22) &&
			({4'd0, p2p_q} >= ssw_q) && ({4'd0, p2p_q} >= dcd_pkg::Q_26);
		unique case (mode_q)
			dcd_pkg::MODE_RELEASE: begin
				if (fast) begin
					nx_mode   = dcd_pkg::MODE_IDLE;
					nx_lastc  = cur_q.now_ms;
					nx_toggle = cur_q.now_ms;
					nx_qv     = 1'b0;
					dclap     = 1'b1;
				end else begin
					if (quiet_q) begin
						if (!qv_q) begin
							nx_qsince = cur_q.now_ms;
							nx_qv     = 1'b1;
						end
						if ((cur_q.now_ms - nx_qsince) >= {24'd0, cfg.quiet_rearm_ms})
							nx_mode = dcd_pkg::MODE_SECOND;
					end else begin
						nx_qv = 1'b0;
					end
					if (dt > {16'd0, cfg.listen_timeout_ms}) begin
						nx_mode = dcd_pkg::MODE_IDLE;
						nx_qv   = 1'b0;
					end
				end
			end
			dcd_pkg::MODE_SECOND: begin
				if (second_cand && (dt >= {20'd0, cfg.gap_min_ms}) &&
						(dt <= {16'd0, cfg.gap_max_ms})) begin
					nx_mode   = dcd_pkg::MODE_IDLE;
					nx_lastc  = cur_q.now_ms;
					nx_toggle = cur_q.now_ms;
					nx_qv     = 1'b0;
					dclap     = 1'b1;
				end else if ((dt > {16'd0, cfg.gap_max_ms}) && first_cand) begin
					nx_mode  = dcd_pkg::MODE_RELEASE;
					nx_stamp = cur_q.now_ms;
					nx_lastc = cur_q.now_ms;
					nx_qv    = 1'b0;
				end else if (dt > {16'd0, cfg.listen_timeout_ms}) begin
					nx_mode = dcd_pkg::MODE_IDLE;
					nx_qv   = 1'b0;
				end
			end
			default: begin
				nx_mode = dcd_pkg::MODE_IDLE;
				if (first_cand && ((cur_q.now_ms - toggle_q) > {20'd0, cfg.cooldown_ms})) begin
					nx_mode  = dcd_pkg::MODE_RELEASE;
					nx_stamp = cur_q.now_ms;
					nx_lastc = cur_q.now_ms;
					nx_qv    = 1'b0;
				end
			end
		endcase
	end

	// sequencer next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			dcd_pkg::ST_IDLE:    if (take) st_d = dcd_pkg::ST_WR;
			dcd_pkg::ST_WR:      st_d = dcd_pkg::ST_SCAN;
			dcd_pkg::ST_SCAN:    if (idx_q == fill_q && !rd_vld_s1) st_d = dcd_pkg::ST_THR;
			dcd_pkg::ST_THR:     st_d = dcd_pkg::ST_REL_DEV;
			dcd_pkg::ST_REL_DEV: st_d = dcd_pkg::ST_REL_SW;
			dcd_pkg::ST_REL_SW:  st_d = dcd_pkg::ST_L_BASE;
			dcd_pkg::ST_L_BASE:  st_d = dcd_pkg::ST_L_DEV;
			dcd_pkg::ST_L_DEV:   st_d = dcd_pkg::ST_L_SW;
			dcd_pkg::ST_L_SW:    st_d = dcd_pkg::ST_DEC;
			dcd_pkg::ST_DEC:     st_d = dcd_pkg::ST_IDLE;
			default:             st_d = dcd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= dcd_pkg::ST_IDLE;
			mode_q    <= dcd_pkg::MODE_IDLE;
			head_q    <= '0;
			fill_q    <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			base_q    <= '0;
			devf_q    <= dcd_pkg::DEVF_RST;
			swf_q     <= dcd_pkg::SWF_RST;
			lastc_q   <= '0;
			stamp_q   <= '0;
			qsince_q  <= '0;
			toggle_q  <= '0;
			qv_q      <= 1'b0;
			bo        <= '0;
		end else begin
			st_q         <= st_d;
			bo.res_valid <= 1'b0;
			rd_vld_s1    <= 1'b0;
			case (st_q)
				dcd_pkg::ST_WR: begin
					head_q <= (head_q == AW'(WINDOW_SAMPLES - 1)) ? '0 : head_q + 1'b1;
					if (fill_q != FW'(WINDOW_SAMPLES)) fill_q <= fill_q + 1'b1;
					if (base_q == '0) base_q <= raw_q16;
					idx_q <= '0;
				end
				dcd_pkg::ST_SCAN: begin
					if (idx_q != fill_q) begin
						idx_q     <= idx_q + 1'b1;
						rd_vld_s1 <= 1'b1;
					end
				end
				// each product lands in prod_q in the cycle after its operands were issued
				dcd_pkg::ST_L_DEV: begin
					if (learn_q) base_q <= new_base;
				end
				dcd_pkg::ST_L_SW: begin
					if (learn_q) devf_q <= new_devf;
				end
				dcd_pkg::ST_DEC: begin
					if (learn_q) swf_q <= new_swf;
					mode_q   <= nx_mode;
					lastc_q  <= nx_lastc;
					stamp_q  <= nx_stamp;
					qsince_q <= nx_qsince;
					toggle_q <= nx_toggle;
					qv_q     <= nx_qv;
					bo.res_valid           <= 1'b1;
					bo.res.double_clap     <= dclap;
					bo.res.waiting_second  <= (nx_mode == dcd_pkg::MODE_RELEASE) ||
						(nx_mode == dcd_pkg::MODE_SECOND);
					bo.res.first_clap_time <= nx_stamp;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (take) cur_q <= head;
		case (st_q)
			dcd_pkg::ST_WR: begin
				wmin_q <= 10'h3FF;
				wmax_q <= 10'h000;
			end
			dcd_pkg::ST_SCAN: begin
				if (rd_vld_s1) begin
					if (rd_data_s1 < wmin_q) wmin_q <= rd_data_s1;
					if (rd_data_s1 > wmax_q) wmax_q <= rd_data_s1;
				end
			end
			dcd_pkg::ST_THR: begin
				dev_q  <= (raw_q16 >= base_q) ? raw_q16 - base_q : base_q - raw_q16;
				p2p_q  <= {wmax_q - wmin_q, 16'd0};
				fdev_q <= fdev_c;
				fsw_q  <= fsw_c;
				sdev_q <= sdev_c;
				ssw_q  <= ssw_c;
			end
			dcd_pkg::ST_REL_SW: begin
				rel_dev_q <= rnd[TW-1:0];
			end
			dcd_pkg::ST_L_BASE: begin
				quiet_q <= quiet_now;
				learn_q <= quiet_now && ((cur_q.now_ms - lastc_q) >= dcd_pkg::LEARN_HOLDOFF);
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/core/double_clap_detector.sv
// Double clap detector, top level: configuration registers, input queue, processing
// back end and result register. Depends on dcd_pkg, dcd_front and dcd_back.
//
// Push one microphone sample with its millisecond timestamp per transaction; every
// sample yields exactly one result transaction carrying the double clap flag, the
// waiting-for-second-clap flag and the time of the latest first clap. The time a
// sample spends in the back end grows with the window fill, set by the peak-to-peak scan
// that reads the filled window entries one per cycle through the single read port of
// the ring memory; thresholds and floor learning then share one multiplier in turn.
// A two-entry queue takes samples while the back end works, and a result register
// holds a finished result until it is popped; the back end starts the next sample
// only once that register is free.
// Configuration writes take effect at once and must be issued only while the block
// is idle.
`default_nettype none
module double_clap_detector #(
	parameter int WINDOW_SAMPLES = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  dcd_pkg::item_t       sample_item,
	output logic                 full,
	output logic                 empty,
	input  wire logic            pop,
	output dcd_pkg::result_t     result,
	input  wire logic            cfg_we,
	input  wire logic [2:0]      cfg_idx,
	input  wire logic [15:0]     cfg_data
);
	dcd_pkg::cfg_t      cfg_q;
	dcd_pkg::item_t     head;
	dcd_pkg::back_out_t bo;
	logic               avail, take, out_v_q, out_busy;

	// configuration registers, masked to their widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lockout_ms        <= 10'd80;
			cfg_q.gap_min_ms        <= 12'd70;
			cfg_q.fast_gap_min_ms   <= 12'd115;
			cfg_q.gap_max_ms        <= 16'd1900;
			cfg_q.listen_timeout_ms <= 16'd2000;
			cfg_q.cooldown_ms       <= 12'd350;
			cfg_q.quiet_rearm_ms    <= 8'd8;
			cfg_q.fast_enable       <= 1'b1;
		end else if (cfg_we) begin
			unique case (dcd_pkg::reg_idx_t'(cfg_idx))
				dcd_pkg::REG_LOCKOUT:      cfg_q.lockout_ms        <= cfg_data[9:0];
				dcd_pkg::REG_GAP_MIN:      cfg_q.gap_min_ms        <= cfg_data[11:0];
				dcd_pkg::REG_FAST_GAP_MIN: cfg_q.fast_gap_min_ms   <= cfg_data[11:0];
				dcd_pkg::REG_GAP_MAX:      cfg_q.gap_max_ms        <= cfg_data;
				dcd_pkg::REG_TIMEOUT:      cfg_q.listen_timeout_ms <= cfg_data;
				dcd_pkg::REG_COOLDOWN:     cfg_q.cooldown_ms       <= cfg_data[11:0];
				dcd_pkg::REG_QUIET_REARM:  cfg_q.quiet_rearm_ms    <= cfg_data[7:0];
				dcd_pkg::REG_FAST_ENABLE:  cfg_q.fast_enable       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	dcd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (sample_item),
		.full   (full),
		.take   (take),
		.avail  (avail),
		.head   (head)
	);

	// hold the back end while a result is landing or still waiting to be popped
	assign out_busy = out_v_q || bo.res_valid;

	dcd_back #(
		.WINDOW_SAMPLES (WINDOW_SAMPLES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.avail    (avail),
		.head     (head),
		.out_busy (out_busy),
		.take     (take),
		.bo       (bo)
	);

	// result register: load from the back end, drop on pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (bo.res_valid) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bo.res_valid) result <= bo.res;
	end

	assign empty = !out_v_q;

	// a finished result never lands on one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		bo.res_valid |-> !out_v_q)
		else $error("result register overwritten");

	// a double clap always leaves the detector idle
	a_dclap_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.double_clap) |-> !result.waiting_second)
		else $error("double clap reported while waiting");

	// the back end takes a transaction only when the queue holds one and no result is waiting
	a_take_avail: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (avail && !out_v_q))
		else $error("take without a queued transaction");

	// a result shows up on the next edge
	a_result_visible: assert property (@(posedge clk) disable iff (!arst_n)
		bo.res_valid |=> !empty)
		else $error("result lost");
endmodule
`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for double_clap_detector: queue-style push/pop traffic with a
// cycle-accurate-free transaction predictor kept in step with every accepted sample.
// Depends on dcd_pkg and the RTL of the detector.
`timescale 1ns / 100ps
`default_nettype none
module tb;

	localparam int  WIN       = 32;
	localparam int  ITEM_GOAL = 1900;
	localparam int  DRAIN_CYC = 120;
	localparam longint CYCLE_LIMIT = 3000000;

	logic             clk;
	logic             arst_n;
	logic             push;
	dcd_pkg::item_t   sample_item;
	logic             full;
	logic             empty;
	logic             pop;
	dcd_pkg::result_t result;
	logic             cfg_we;
	logic [2:0]       cfg_idx;
	logic [15:0]      cfg_data;

	double_clap_detector #(.WINDOW_SAMPLES(WIN)) u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .sample_item(sample_item), .full(full),
		.empty(empty), .pop(pop), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// Stimulus and expectation stores
	dcd_pkg::item_t   sample_queue[$];
	dcd_pkg::result_t clap_expect[$];
	int      mismatches;
	longint  cycles;
	bit      tx_idle_en;
	bit      rx_idle_en;
	int      tx_gap;
	int      rx_gap;

	// Predictor state, kept in Q10.16 as signed 64-bit values
	dcd_pkg::cfg_t  cfg_m;
	dcd_pkg::mode_t mode_m;
	longint      base_lvl;
	longint      dev_floor;
	longint      sw_floor;
	int          ring_m[WIN];
	int          head_m;
	int          fill_m;
	bit [31:0]   last_cand;
	bit [31:0]   first_stamp;
	bit [31:0]   quiet_since;
	bit [31:0]   last_toggle;
	bit          quiet_ok;

	// Stimulus timeline
	bit [31:0] now_t;
	int        level;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint rnd16(longint x);
		return (x + 64'sd32768) >>> 16;
	endfunction

	function automatic longint lmax(longint a, longint b);
		return (a > b) ? a : b;
	endfunction

	function automatic longint lclamp(longint x);
		if (x < 0)
			return 0;
		if (x > 64'h3FFFFFF)
			return 64'h3FFFFFF;
		return x;
	endfunction

	function automatic int pick_gap(bit en);
		int r;
		r = $urandom_range(0, 99);
		if (!en || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(40, 200);
	endfunction

	// Work out the result of one accepted sample and advance the predictor state.
	task automatic clap_predict(input dcd_pkg::item_t it);
		longint    raw_q, dev, p2p_q, fdev, fsw, sdev, ssw, rdev, rsw;
		int        wmin, wmax;
		bit        quiet, locked, fc, sc, dclap, fast;
		bit [31:0] now, dt, since_cand;
		dcd_pkg::result_t r;
		now   = it.now_ms;
		dclap = 1'b0;
		raw_q = longint'(it.sample) << 16;
		ring_m[head_m] = it.sample;
		head_m = (head_m + 1) % WIN;
		if (fill_m < WIN)
			fill_m++;
		if (base_lvl <= 0)
			base_lvl = raw_q;
		dev = (raw_q >= base_lvl) ? raw_q - base_lvl : base_lvl - raw_q;
		wmin = 1023;
		wmax = 0;
		for (int i = 0; i < fill_m; i++) begin
			if (ring_m[i] < wmin) wmin = ring_m[i];
			if (ring_m[i] > wmax) wmax = ring_m[i];
		end
		p2p_q = longint'(wmax - wmin) << 16;
		fdev = lmax(18 * 65536, dev_floor * 6 + 6 * 65536);
		fsw  = lmax(24 * 65536, sw_floor * 4 + 4 * 65536);
		sdev = lmax(14 * 65536, ((dev_floor * 9 + 1) >>> 1) + 6 * 65536);
		ssw  = lmax(16 * 65536, sw_floor * 3 + 4 * 65536);
		rdev = rnd16(sdev * 43254);
		rsw  = rnd16(ssw * 43254);
		quiet = (dev <= rdev) && (p2p_q <= rsw);
		since_cand = now - last_cand;
		// Floors learn only when quiet and well clear of the last candidate
		if (quiet && since_cand >= 32'd250) begin
			base_lvl  = lclamp(base_lvl + rnd16((raw_q - base_lvl) * 393));
			dev_floor = lclamp(dev_floor + rnd16((dev - dev_floor) * 983));
			sw_floor  = lclamp(sw_floor + rnd16((p2p_q - sw_floor) * 983));
			if (dev_floor < 39322) dev_floor = 39322;
			if (sw_floor < 2 * 65536) sw_floor = 2 * 65536;
			if (sw_floor > 80 * 65536) sw_floor = 80 * 65536;
		end
		locked = since_cand < 32'(cfg_m.lockout_ms);
		fc = !locked && (dev >= fdev || (p2p_q >= fsw && dev >= 10 * 65536));
		sc = !locked && (dev >= sdev || (p2p_q >= ssw && dev >= 6 * 65536));
		dt = now - first_stamp;
		case (mode_m)
			dcd_pkg::MODE_RELEASE: begin
				fast = cfg_m.fast_enable && !locked && dt >= 32'(cfg_m.fast_gap_min_ms) &&
					dt <= 32'(cfg_m.gap_max_ms) && dev >= lmax(sdev, 22 * 65536) &&
					p2p_q >= lmax(ssw, 26 * 65536);
				if (fast) begin
					mode_m = dcd_pkg::MODE_IDLE; last_cand = now; last_toggle = now;
					quiet_ok = 1'b0;
					dclap = 1'b1;
				end else begin
					if (quiet) begin
						if (!quiet_ok) begin
							quiet_since = now;
							quiet_ok = 1'b1;
						end
						if (now - quiet_since >= 32'(cfg_m.quiet_rearm_ms))
							mode_m = dcd_pkg::MODE_SECOND;
					end else begin
						quiet_ok = 1'b0;
					end
					if (dt > 32'(cfg_m.listen_timeout_ms)) begin
						mode_m = dcd_pkg::MODE_IDLE;
						quiet_ok = 1'b0;
					end
				end
			end
			dcd_pkg::MODE_SECOND: begin
				if (sc && dt >= 32'(cfg_m.gap_min_ms) && dt <= 32'(cfg_m.gap_max_ms)) begin
					mode_m = dcd_pkg::MODE_IDLE; last_cand = now; last_toggle = now;
					quiet_ok = 1'b0;
					dclap = 1'b1;
				end else if (dt > 32'(cfg_m.gap_max_ms) && fc) begin
					mode_m = dcd_pkg::MODE_RELEASE; first_stamp = now; last_cand = now;
					quiet_ok = 1'b0;
				end else if (dt > 32'(cfg_m.listen_timeout_ms)) begin
					mode_m = dcd_pkg::MODE_IDLE;
					quiet_ok = 1'b0;
				end
			end
			default: begin
				mode_m = dcd_pkg::MODE_IDLE;
				if (fc && (now - last_toggle) > 32'(cfg_m.cooldown_ms)) begin
					mode_m = dcd_pkg::MODE_RELEASE; first_stamp = now; last_cand = now;
					quiet_ok = 1'b0;
				end
			end
		endcase
		r.double_clap     = dclap;
		r.waiting_second  = (mode_m == dcd_pkg::MODE_RELEASE) ||
			(mode_m == dcd_pkg::MODE_SECOND);
		r.first_clap_time = first_stamp;
		clap_expect.push_back(r);
	endtask

	// Driver: hold the transaction until it is taken, then advance to the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push        <= 1'b0;
			sample_item <= '0;
			tx_gap      <= 0;
		end else begin
			if (push && !full)
				clap_predict(sample_item);
			if (!push || !full) begin
				if (tx_gap > 0) begin
					tx_gap <= tx_gap - 1;
					push   <= 1'b0;
				end else if (sample_queue.size() > 0) begin
					sample_item <= sample_queue.pop_front();
					push        <= 1'b1;
					tx_gap      <= pick_gap(tx_idle_en);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each popped result against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop    <= 1'b0;
			rx_gap <= 0;
		end else begin
			if (pop && !empty) begin
				if (clap_expect.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result transaction: %p", result);
				end else begin
					dcd_pkg::result_t e;
					e = clap_expect.pop_front();
					if (result.double_clap !== e.double_clap ||
						result.waiting_second !== e.waiting_second ||
						result.first_clap_time !== e.first_clap_time) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"Mismatch: expected clap=%0b wait=%0b first=%h,",
								" got clap=%0b wait=%0b first=%h"},
								e.double_clap, e.waiting_second, e.first_clap_time,
								result.double_clap, result.waiting_second,
								result.first_clap_time);
					end
				end
			end
			if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				pop    <= 1'b0;
			end else begin
				pop    <= 1'b1;
				rx_gap <= pick_gap(rx_idle_en);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic add_sample(input int s, input int step);
		dcd_pkg::item_t it;
		now_t     = now_t + 32'(step);
		it.sample = 10'(s);
		it.now_ms = now_t;
		sample_queue.push_back(it);
	endtask

	task automatic add_quiet(input int n, input int max_step);
		for (int i = 0; i < n; i++)
			add_sample(level + $urandom_range(0, 2) - 1, $urandom_range(1, max_step));
	endtask

	task automatic add_clap();
		int amp;
		amp = $urandom_range(30, 500);
		for (int i = 0; i < $urandom_range(1, 4); i++) begin
			if ($urandom_range(0, 1))
				add_sample((level + amp > 1023) ? 1023 : level + amp, 1);
			else
				add_sample((level - amp < 0) ? 0 : level - amp, 1);
		end
	endtask

	// Mostly well-formed clap patterns with random spacing, plus noise.
	task automatic add_random_traffic(input int n);
		int stop, r;
		stop = sample_queue.size() + n;
		while (sample_queue.size() < stop) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				add_quiet($urandom_range(5, 30), 40);
				add_clap();
				add_quiet($urandom_range(30, 50), $urandom_range(1, 50));
				add_clap();
				add_quiet($urandom_range(2, 10), 30);
			end else if (r < 80) begin
				add_quiet($urandom_range(5, 20), 60);
				add_clap();
			end else if (r < 90) begin
				for (int i = 0; i < 10; i++)
					add_sample($urandom_range(0, 1023),
						($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 5));
			end else begin
				level = $urandom_range(100, 900);
				add_quiet(10, 400);
			end
		end
	endtask

	task automatic write_reg(input dcd_pkg::reg_idx_t idx, input int val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= 16'(val);
		case (idx)
			dcd_pkg::REG_LOCKOUT:      cfg_m.lockout_ms        = 10'(val);
			dcd_pkg::REG_GAP_MIN:      cfg_m.gap_min_ms        = 12'(val);
			dcd_pkg::REG_FAST_GAP_MIN: cfg_m.fast_gap_min_ms   = 12'(val);
			dcd_pkg::REG_GAP_MAX:      cfg_m.gap_max_ms        = 16'(val);
			dcd_pkg::REG_TIMEOUT:      cfg_m.listen_timeout_ms = 16'(val);
			dcd_pkg::REG_COOLDOWN:     cfg_m.cooldown_ms       = 12'(val);
			dcd_pkg::REG_QUIET_REARM:  cfg_m.quiet_rearm_ms    = 8'(val);
			default:                   cfg_m.fast_enable       = 1'(val);
		endcase
		@(posedge clk);
	endtask

	task automatic write_all(input int lo, input int gmin, input int fgmin, input int gmax,
		input int tmo, input int cool, input int rearm, input int fen);
		write_reg(dcd_pkg::REG_LOCKOUT, lo);
		write_reg(dcd_pkg::REG_GAP_MIN, gmin);
		write_reg(dcd_pkg::REG_FAST_GAP_MIN, fgmin);
		write_reg(dcd_pkg::REG_GAP_MAX, gmax);
		write_reg(dcd_pkg::REG_TIMEOUT, tmo);
		write_reg(dcd_pkg::REG_COOLDOWN, cool);
		write_reg(dcd_pkg::REG_QUIET_REARM, rearm);
		write_reg(dcd_pkg::REG_FAST_ENABLE, fen);
		cfg_we <= 1'b0;
	endtask

	// Wait for every pending transaction to drain, then let the block settle.
	task automatic drain();
		while (sample_queue.size() > 0 || push || clap_expect.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	initial begin
		mismatches = 0;
		cycles     = 0;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		cfg_we     = 1'b0;
		cfg_idx    = dcd_pkg::REG_LOCKOUT;
		cfg_data   = '0;
		cfg_m      = '{lockout_ms: 10'd80, gap_min_ms: 12'd70, fast_gap_min_ms: 12'd115,
			gap_max_ms: 16'd1900, listen_timeout_ms: 16'd2000, cooldown_ms: 12'd350,
			quiet_rearm_ms: 8'd8, fast_enable: 1'b1};
		mode_m      = dcd_pkg::MODE_IDLE;
		base_lvl    = 0;
		dev_floor   = 65536;
		sw_floor    = 6 * 65536;
		head_m      = 0;
		fill_m      = 0;
		last_cand   = '0;
		first_stamp = '0;
		quiet_since = '0;
		last_toggle = '0;
		quiet_ok    = 1'b0;
		arst_n      = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reseeding on a zero sample, field extremes, timestamp wrap, then a
		// clean double clap at the reset settings.
		now_t = 32'd0;
		add_sample(0, 0);
		add_sample(0, 0);
		add_sample(1023, 32'hFFFF_FFFE);
		add_sample(10'h155, 1);
		add_sample(10'h2AA, 1);
		add_sample(1023, 0);
		level = 512;
		add_quiet(4, 300);
		add_clap();
		add_quiet(6, 40);
		add_clap();
		add_quiet(2, 1);
		drain();

		// Phase with reset settings, no idling on either side
		add_random_traffic(350);
		drain();

		// All registers at their lowest
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		write_all(0, 0, 0, 0, 0, 0, 0, 0);
		add_random_traffic(350);
		drain();

		// All registers at their highest
		write_all(1023, 4095, 4095, 65535, 65535, 4095, 255, 1);
		add_random_traffic(350);
		drain();

		// Random settings around useful values, with idling mixed per phase
		for (int p = 0; p < 3; p++) begin
			tx_idle_en = $urandom_range(0, 1);
			rx_idle_en = $urandom_range(0, 1);
			write_all($urandom_range(0, 200), $urandom_range(0, 300), $urandom_range(0, 400),
				$urandom_range(200, 3000), $urandom_range(200, 3000),
				$urandom_range(0, 600), $urandom_range(0, 40), $urandom_range(0, 1));
			add_random_traffic((ITEM_GOAL - 1050) / 3);
			drain();
		end

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire

>>> files.f
rtl/core/dcd_pkg.sv
rtl/core/dcd_front.sv
rtl/core/dcd_back.sv
rtl/core/double_clap_detector.sv
bench/tb.sv
